>>> rtl/core/deq_pkg.sv
// shared constants, codes and beat types of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  // ring depth, a power of two so ring positions wrap by truncation
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  localparam int CMD_W = 3;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] item;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } rsp_t;

  // write request into the ring store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  // read request into the ring store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

endpackage

>>> rtl/core/double_ended_queue.sv
// top level of the double-ended byte queue built on a ring store
`timescale 1ns / 1ps

// double-ended queue of bytes held in a DEPTH-entry ring store
// cmd channel: one beat per command (push back, push front, pop back,
//   pop front, list); rsp channel: result beats, last marks the final one
// pushes and all commands that fail or do nothing answer from the output
//   register in the cycle after acceptance and can be taken every cycle
//   while the receiver keeps up; pops answer from the output register once
//   the store's registered read data is back, with no command taken between
// a list streams front to back out of the store's single read port, one
//   beat per cycle unless stalled; no command until its last beat is loaded
// a command is taken only while the output register is empty or being
//   drained in the same cycle, so a stalled receiver stalls the command side
// reset empties the queue (front and fill count cleared) and drops any
//   pending beat; the store contents are not cleared and need no pass
// full inserts get status full, pops and lists on an empty queue get
//   status empty, unknown command codes answer ok and change nothing

module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  deq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  // control state
  deq_pkg::state_t             state, state_next;
  logic [deq_pkg::ADDR_W-1:0]  front_index, front_index_next;
  logic [deq_pkg::CNT_W-1:0]   fill_count, fill_count_next;
  logic [deq_pkg::CNT_W-1:0]   list_idx, list_idx_next;

  // output register
  logic                        rsp_load;
  deq_pkg::rsp_t               rsp_next;

  // store ports
  deq_pkg::wr_req_t            wr;
  deq_pkg::rd_req_t            rd;
  logic [deq_pkg::BYTE_W-1:0]  rd_data;

  logic                        accept;
  logic                        out_free;
  logic                        is_full;
  logic                        is_empty;
  logic                        list_last;

  deq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == deq_pkg::S_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign is_full   = fill_count == deq_pkg::CNT_W'(deq_pkg::DEPTH);
  assign is_empty  = fill_count == '0;
  assign list_last = (list_idx + deq_pkg::CNT_W'(1)) == fill_count;

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    fill_count_next  = fill_count;
    list_idx_next    = list_idx;
    rsp_load         = 1'b0;
    rsp_next         = rsp;
    wr               = '0;
    rd               = '0;

    unique case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          // default single-beat answer, occupancy patched per command
          rsp_next.value     = '0;
          rsp_next.status    = deq_pkg::ST_OK;
          rsp_next.occupancy = deq_pkg::OCC_W'(fill_count);
          rsp_next.last      = 1'b1;
          unique case (cmd.command)
            deq_pkg::CMD_PUSH_BACK: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_next.status = deq_pkg::ST_FULL;
              end else begin
                wr.en   = 1'b1;
                wr.addr = front_index + deq_pkg::ADDR_W'(fill_count);
                wr.data = cmd.item;
                fill_count_next    = fill_count + deq_pkg::CNT_W'(1);
                rsp_next.occupancy = deq_pkg::OCC_W'(fill_count_next);
              end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_next.status = deq_pkg::ST_FULL;
              end else begin
                front_index_next   = front_index - deq_pkg::ADDR_W'(1);
                wr.en   = 1'b1;
                wr.addr = front_index_next;
                wr.data = cmd.item;
                fill_count_next    = fill_count + deq_pkg::CNT_W'(1);
                rsp_next.occupancy = deq_pkg::OCC_W'(fill_count_next);
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = deq_pkg::ST_EMPTY;
              end else begin
                rd.en   = 1'b1;
                rd.addr = front_index + deq_pkg::ADDR_W'(fill_count - deq_pkg::CNT_W'(1));
                fill_count_next = fill_count - deq_pkg::CNT_W'(1);
                state_next      = deq_pkg::S_POP;
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = deq_pkg::ST_EMPTY;
              end else begin
                rd.en   = 1'b1;
                rd.addr = front_index;
                front_index_next = front_index + deq_pkg::ADDR_W'(1);
                fill_count_next  = fill_count - deq_pkg::CNT_W'(1);
                state_next       = deq_pkg::S_POP;
              end
            end
            deq_pkg::CMD_LIST: begin
              if (is_empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = deq_pkg::ST_EMPTY;
              end else begin
                // fetch the front entry, stream from the next cycle on
                rd.en         = 1'b1;
                rd.addr       = front_index;
                list_idx_next = '0;
                state_next    = deq_pkg::S_LIST;
              end
            end
            default: begin
              // unused codes answer ok and change nothing
              rsp_load = 1'b1;
            end
          endcase
        end
      end

      deq_pkg::S_POP: begin
        // output register was emptied when the pop was taken
        rsp_load           = 1'b1;
        rsp_next.value     = rd_data;
        rsp_next.status    = deq_pkg::ST_OK;
        rsp_next.occupancy = deq_pkg::OCC_W'(fill_count);
        rsp_next.last      = 1'b1;
        state_next         = deq_pkg::S_IDLE;
      end

      deq_pkg::S_LIST: begin
        // read data holds while the output register is stalled
        if (out_free) begin
          rsp_load           = 1'b1;
          rsp_next.value     = rd_data;
          rsp_next.status    = deq_pkg::ST_OK;
          rsp_next.occupancy = deq_pkg::OCC_W'(fill_count);
          rsp_next.last      = list_last;
          if (list_last) begin
            state_next = deq_pkg::S_IDLE;
          end else begin
            list_idx_next = list_idx + deq_pkg::CNT_W'(1);
            rd.en         = 1'b1;
            rd.addr       = front_index + deq_pkg::ADDR_W'(list_idx_next);
          end
        end
      end

      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= deq_pkg::S_IDLE;
      front_index <= '0;
      fill_count  <= '0;
      list_idx    <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      fill_count  <= fill_count_next;
      list_idx    <= list_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // beat payload, no reset needed
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // the fill count never exceeds the ring depth
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("fill count beyond ring depth");

  // a pop waiting on read data always finds the output register empty
  assert property (@(posedge clk) disable iff (rst)
    state == deq_pkg::S_POP |-> !rsp_valid)
    else $error("pop result would overwrite a pending beat");

  // a pending beat without the last marker belongs to a running list
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> state == deq_pkg::S_LIST)
    else $error("non-final beat outside a list");

  // a push back into a queue with room grows it by one
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.command == deq_pkg::CMD_PUSH_BACK && !is_full
    |=> fill_count == $past(fill_count) + deq_pkg::CNT_W'(1))
    else $error("push back did not grow the queue");

endmodule

>>> rtl/core/deq_ram.sv
// ring store: one write port, one read port, registered read data
`timescale 1ns / 1ps

module deq_ram (
  input  logic                       clk,
  input  deq_pkg::wr_req_t           wr,
  input  deq_pkg::rd_req_t           rd,
  output logic [deq_pkg::BYTE_W-1:0] rd_data
);

  logic [deq_pkg::BYTE_W-1:0] mem [deq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read request
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the double-ended byte queue

module testbench;
  import deq_pkg::*;

  // cycles with no beat on either channel before the run is given up
  localparam int STALL_LIMIT = 2000;
  // cycles left after the last expected beat for stray beats to show up
  localparam int TAIL_CYCLES = 8;
  localparam int N_DIRECTED  = 18;
  localparam int N_RANDOM    = 100;

  // command codes the block does not use; they must answer ok and change nothing
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  // kinds of random episode
  localparam int EP_FILL  = 0;
  localparam int EP_DRAIN = 1;
  localparam int EP_MIX   = 2;

  // one row of the directed table: the command, and where the answer is
  // obvious, the single beat it must produce (else the predictor decides)
  typedef struct packed {
    cmd_t c;
    logic typed;
    rsp_t want;
  } cmd_row_t;

  // walks empty cases, both insert sides, listings, both removal sides,
  // unused codes and a front insert that wraps the ring backwards
  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_POP_BACK,   8'h00}, 1'b1, '{8'h00, ST_EMPTY, 5'd0, 1'b1}},
    '{'{CMD_POP_FRONT,  8'hff}, 1'b1, '{8'h00, ST_EMPTY, 5'd0, 1'b1}},
    '{'{CMD_LIST,       8'h00}, 1'b1, '{8'h00, ST_EMPTY, 5'd0, 1'b1}},
    '{'{CMD_RSVD_HI,    8'hff}, 1'b1, '{8'h00, ST_OK,    5'd0, 1'b1}},
    '{'{CMD_PUSH_BACK,  8'h00}, 1'b1, '{8'h00, ST_OK,    5'd1, 1'b1}},
    '{'{CMD_PUSH_FRONT, 8'hff}, 1'b1, '{8'h00, ST_OK,    5'd2, 1'b1}},
    '{'{CMD_PUSH_BACK,  8'ha5}, 1'b1, '{8'h00, ST_OK,    5'd3, 1'b1}},
    '{'{CMD_PUSH_FRONT, 8'h5a}, 1'b1, '{8'h00, ST_OK,    5'd4, 1'b1}},
    '{'{CMD_LIST,       8'hc3}, 1'b0, '0},
    '{'{CMD_RSVD_LO,    8'h3c}, 1'b1, '{8'h00, ST_OK,    5'd4, 1'b1}},
    '{'{CMD_POP_FRONT,  8'h00}, 1'b1, '{8'h5a, ST_OK,    5'd3, 1'b1}},
    '{'{CMD_POP_BACK,   8'h00}, 1'b1, '{8'ha5, ST_OK,    5'd2, 1'b1}},
    '{'{CMD_POP_BACK,   8'h00}, 1'b1, '{8'h00, ST_OK,    5'd1, 1'b1}},
    '{'{CMD_LIST,       8'h00}, 1'b0, '0},
    '{'{CMD_POP_FRONT,  8'h00}, 1'b1, '{8'hff, ST_OK,    5'd0, 1'b1}},
    '{'{CMD_POP_FRONT,  8'h00}, 1'b1, '{8'h00, ST_EMPTY, 5'd0, 1'b1}},
    '{'{CMD_PUSH_FRONT, 8'h81}, 1'b1, '{8'h00, ST_OK,    5'd1, 1'b1}},
    '{'{CMD_POP_BACK,   8'h00}, 1'b1, '{8'h81, ST_OK,    5'd0, 1'b1}}
  };

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // predicted contents of the queue
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [ADDR_W-1:0] ring_front = '0;
  logic [CNT_W-1:0]  ring_fill  = '0;

  // beats the block still owes, oldest first
  rsp_t expected_rsp [$];
  rsp_t beat_want;

  // while set, neither side idles
  bit steady = 1'b0;

  int errors       = 0;
  int n_beats      = 0;
  int n_sent       = 0;
  int stall_cycles = 0;
  int n_push       = 0;
  int n_pop        = 0;
  int n_list       = 0;
  int n_rsvd       = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int longest_list = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // receiver: holds off about a quarter of the cycles, except in the steady stretch
  always @(negedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= 25);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch: %s at beat %0d, got %0d expected %0d (t=%0t)",
               what, n_beats, got, want, $time);
    end
  endtask

  // compare every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      n_beats++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("beat with nothing expected", int'(rsp), 0);
      end else begin
        beat_want = expected_rsp.pop_front();
        if (rsp.value !== beat_want.value)
          report_mismatch("value", int'(rsp.value), int'(beat_want.value));
        if (rsp.status !== beat_want.status)
          report_mismatch("status", int'(rsp.status), int'(beat_want.status));
        if (rsp.occupancy !== beat_want.occupancy)
          report_mismatch("occupancy", int'(rsp.occupancy), int'(beat_want.occupancy));
        if (rsp.last !== beat_want.last)
          report_mismatch("last", int'(rsp.last), int'(beat_want.last));
      end
    end
  end

  // watchdog: too long without any beat on either channel ends the run
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats still owed",
               stall_cycles, expected_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // updates the predicted queue for one accepted command and queues
  // the result beats it must cause
  task automatic predict_deque(input cmd_t c);
    rsp_t              beat;
    logic [ADDR_W-1:0] pos;
    beat      = '0;
    beat.last = 1'b1;
    case (c.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        n_push++;
        if (ring_fill == CNT_W'(DEPTH)) begin
          // refused, nothing moves
          beat.status = ST_FULL;
          n_full++;
        end else begin
          if (c.command == CMD_PUSH_BACK) begin
            pos = ring_front + ring_fill[ADDR_W-1:0];
          end else begin
            // front moves one slot back, wrapping below zero
            ring_front = ring_front - ADDR_W'(1);
            pos        = ring_front;
          end
          ring_mem[pos] = c.item;
          ring_fill     = ring_fill + CNT_W'(1);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        n_pop++;
        if (ring_fill == '0) begin
          beat.status = ST_EMPTY;
          n_empty++;
        end else begin
          if (c.command == CMD_POP_BACK) begin
            pos = ring_front + ADDR_W'(ring_fill - CNT_W'(1));
          end else begin
            pos        = ring_front;
            ring_front = ring_front + ADDR_W'(1);
          end
          beat.value = ring_mem[pos];
          ring_fill  = ring_fill - CNT_W'(1);
        end
      end
      CMD_LIST: begin
        n_list++;
        if (ring_fill == '0) begin
          beat.status = ST_EMPTY;
          n_empty++;
        end else begin
          // one beat per entry, front to back, last on the final one
          for (int i = 0; i < int'(ring_fill); i++) begin
            pos            = ring_front + ADDR_W'(i);
            beat.value     = ring_mem[pos];
            beat.occupancy = OCC_W'(ring_fill);
            beat.last      = (i == int'(ring_fill) - 1);
            expected_rsp.push_back(beat);
          end
          if (int'(ring_fill) > longest_list) longest_list = int'(ring_fill);
          return;
        end
      end
      default: begin
        n_rsvd++;
      end
    endcase
    beat.occupancy = OCC_W'(ring_fill);
    expected_rsp.push_back(beat);
  endtask

  // sender: called at a falling edge, returns at the falling edge after
  // the beat is taken; valid stays high into the next call unless it idles
  task automatic issue_cmd(input cmd_t c, input logic typed, input rsp_t want);
    int gap;
    if (!steady && $urandom_range(99) < 25) begin
      gap = $urandom_range(4, 1);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predict_deque(c);
    // a typed row replaces the single predicted beat with the table's answer
    if (typed) begin
      void'(expected_rsp.pop_back());
      expected_rsp.push_back(want);
    end
    n_sent++;
    @(negedge clk);
  endtask

  // sender stands back until every owed beat has come
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    cmd_t c;
    int   ep_kind;
    int   episode;
    int   r;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();

    // random episodes: fill to full and past it, drain to empty and past it,
    // or a mixed run; the first two are always a fill and a drain
    episode = 0;
    while (n_sent < N_DIRECTED + N_RANDOM) begin
      steady = (n_sent >= N_DIRECTED + 50) && (n_sent < N_DIRECTED + 85);
      if (episode == 0) begin
        ep_kind = EP_FILL;
      end else if (episode == 1) begin
        ep_kind = EP_DRAIN;
      end else begin
        r       = $urandom_range(3);
        ep_kind = (r == 0) ? EP_FILL : (r == 1) ? EP_DRAIN : EP_MIX;
      end
      // once mid-run the sender holds until the block has answered everything
      if (episode == 4) wait_drained();

      case (ep_kind)
        EP_FILL: begin
          while (ring_fill < CNT_W'(DEPTH)) begin
            c.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            c.item    = BYTE_W'($urandom_range(255));
            issue_cmd(c, 1'b0, '0);
          end
          // inserts into a full queue
          repeat ($urandom_range(2, 1)) begin
            c.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            c.item    = BYTE_W'($urandom_range(255));
            issue_cmd(c, 1'b0, '0);
          end
          // full listing, the longest burst of result beats
          c.command = CMD_LIST;
          c.item    = BYTE_W'($urandom_range(255));
          issue_cmd(c, 1'b0, '0);
        end
        EP_DRAIN: begin
          while (ring_fill > '0) begin
            c.command = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            c.item    = BYTE_W'($urandom_range(255));
            issue_cmd(c, 1'b0, '0);
          end
          // removal from an empty queue, sometimes a listing too
          c.command = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
          issue_cmd(c, 1'b0, '0);
          if ($urandom_range(1)) begin
            c.command = CMD_LIST;
            issue_cmd(c, 1'b0, '0);
          end
        end
        default: begin
          repeat (10) begin
            r      = $urandom_range(99);
            c.item = BYTE_W'($urandom_range(255));
            if (r < 35) begin
              c.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end else if (r < 70) begin
              c.command = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end else if (r < 85) begin
              c.command = CMD_LIST;
            end else begin
              c.command = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            end
            issue_cmd(c, 1'b0, '0);
          end
        end
      endcase
      episode++;
    end
    steady = 1'b0;

    // let the block answer everything, then watch a little longer for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      report_mismatch("beats never delivered", 0, expected_rsp.size());
    end

    $display("run: %0d inserts, %0d removals, %0d listings, %0d unused codes, %0d beats checked",
             n_push, n_pop, n_list, n_rsvd, n_beats);
    $display("run: %0d refused full inserts, %0d empty answers, longest listing %0d entries",
             n_full, n_empty, longest_list);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue.sv
test/testbench.sv
